>>> src/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg: shared types and constants of the sigma-clipped common-mode block
// Store size, field widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int MaxSamples = 128;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int SampleW    = 16;
  // Sum of all samples, then shifted by 8 fraction bits.
  localparam int SumW       = SampleW + CntW;
  localparam int MeanW      = SumW + 8;
  // Deviation magnitude, its square, and the sum of squares.
  localparam int DevW       = SampleW + 8 + 1;
  localparam int SqW        = 2 * DevW;
  localparam int SumSqW     = SqW + CntW;
  // Both sides of the keep compare.
  localparam int CmpW       = SumSqW + 8;

  localparam logic [0:0] RegMaxIter = 1'b0;
  localparam logic [0:0] RegClip    = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_SQ,
    ST_CLIP,
    ST_NEXT,
    ST_OUT
  } state_t;

  // Commands from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

>>> src/scm_div.sv
// ----------------------------------------------------------------------------
// scm_div: restoring divider, one quotient bit per cycle
// Computes floor(num / den) for the pass mean.
// ----------------------------------------------------------------------------
module scm_div
  import scm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  input  logic [MeanW-1:0] num,
  input  logic [CntW-1:0]  den,
  output logic             busy,
  output logic [MeanW-1:0] quot
);

  localparam int StepW = $clog2(MeanW + 1);

  logic [MeanW-1:0] rem;
  logic [MeanW-1:0] rem_next;
  logic [MeanW-1:0] dvd;
  logic [CntW-1:0]  dvs;
  logic [StepW-1:0] steps;
  logic [MeanW:0]   trial;

  // Shift in one dividend bit and try a subtract.
  always_comb begin
    trial    = {rem, dvd[MeanW-1]};
    rem_next = trial[MeanW-1:0];
    if (trial >= {{(MeanW + 1 - CntW){1'b0}}, dvs}) begin
      rem_next = MeanW'(trial - {{(MeanW + 1 - CntW){1'b0}}, dvs});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      steps <= StepW'(MeanW);
      rem   <= '0;
      dvd   <= num;
      dvs   <= den;
      quot  <= '0;
    end else if (busy) begin
      rem   <= rem_next;
      dvd   <= {dvd[MeanW-2:0], 1'b0};
      quot  <= {quot[MeanW-2:0], (trial >= {{(MeanW + 1 - CntW){1'b0}}, dvs})};
      steps <= steps - 1'b1;
      if (steps == StepW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> src/sigma_clipped_common_mode.sv
// ----------------------------------------------------------------------------
// sigma_clipped_common_mode: iterative sigma-clipped mean of one sample group
// Stores a group, then runs clipping passes through one shared datapath.
// ----------------------------------------------------------------------------
// A sample item takes one cycle while the group loads. The item marked last
// starts the evaluation; stall stays high until its result is taken. Each
// pass has a start step, a sum walk over the store at one stored sample per
// cycle, a bit-serial divide for the mean, then sum-of-squares and keep
// walks at the same rate, each ending once its read and square registers
// drain; up to max_iterations passes run, then the result waits until it
// is taken. The store has one read port, read once per cycle by the walks.
module sigma_clipped_common_mode
  import scm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         valid,
  output logic         stall,
  input  logic [15:0]  sample,
  input  logic         last,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [23:0]  common_mode,
  output logic [7:0]   kept_count,
  output logic         overflow,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  state_t state, state_next;

  logic [3:0]       max_iter;
  logic [3:0]       clip;
  logic [SampleW-1:0] store [MaxSamples];
  logic [MaxSamples-1:0] keep;
  logic [CntW-1:0]  load_cnt;
  logic             ovf;
  logic [CntW-1:0]  kept;
  logic [CntW-1:0]  still;
  logic [3:0]       pass;
  logic [MeanW-1:0] mean;
  logic [MeanW-1:0] result;
  logic [SumW-1:0]  sum;
  logic [SumSqW-1:0] sumsq;
  logic [CntW-1:0]  idx;
  logic [SampleW-1:0] rd_data;
  logic             rd_ok;
  logic [AddrW-1:0] rd_addr;
  logic             walk_done;
  logic [SqW-1:0]   sq;
  logic             sq_ok;
  logic [AddrW-1:0] sq_addr;
  logic [DevW-1:0]  dev;
  logic [CmpW-1:0]  lhs;
  logic [CmpW-1:0]  rhs;
  logic [7:0]       clip_sq;
  div_ctl_t         div_ctl;
  logic             div_busy;
  logic             div_wait;
  logic [MeanW-1:0] quot;
  logic             take;

  assign take  = valid && !stall;
  assign stall = (state != ST_LOAD);

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= 4'd10;
      clip     <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMaxIter: max_iter <= cfg_data;
        RegClip:    clip     <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Sample memory: written while loading; the read at idx is registered.
  always_ff @(posedge clk) begin
    if (take && (load_cnt < CntW'(MaxSamples))) begin
      store[load_cnt[AddrW-1:0]] <= sample;
    end
    rd_data <= store[idx[AddrW-1:0]];
  end

  scm_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .num ({sum, 8'd0}),
    .den (kept),
    .busy(div_busy),
    .quot(quot)
  );

  assign walk_done = (idx >= load_cnt);
  assign clip_sq   = {4'd0, clip} * {4'd0, clip};

  // Deviation of the read sample, squared in the next stage.
  always_comb begin
    if (mean > {{(MeanW - SampleW - 8){1'b0}}, rd_data, 8'd0}) begin
      dev = DevW'(mean - {{(MeanW - SampleW - 8){1'b0}}, rd_data, 8'd0});
    end else begin
      dev = DevW'({{(MeanW - SampleW - 8){1'b0}}, rd_data, 8'd0} - mean);
    end
  end

  // Keep test operands.
  assign lhs = CmpW'(sq) * CmpW'(kept);
  assign rhs = CmpW'(sumsq) * CmpW'(clip_sq);

  // Sequencer.
  always_comb begin
    state_next = state;
    div_ctl    = '{start: 1'b0};
    case (state)
      ST_LOAD: begin
        if (take && last) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (pass == max_iter || kept == '0) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (walk_done && !rd_ok) begin
          state_next    = ST_DIV;
          div_ctl.start = 1'b1;
        end
      end
      ST_DIV: begin
        if (!div_busy && !div_wait) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        if (walk_done && !rd_ok && !sq_ok) begin
          state_next = ST_CLIP;
        end
      end
      ST_CLIP: begin
        if (walk_done && !rd_ok && !sq_ok) begin
          state_next = ST_NEXT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep     <= '0;
      load_cnt <= '0;
      kept     <= '0;
      ovf      <= 1'b0;
      rd_ok    <= 1'b0;
      sq_ok    <= 1'b0;
      div_wait <= 1'b0;
      idx      <= '0;
      pass     <= '0;
      result   <= '0;
    end else begin
      rd_ok    <= 1'b0;
      sq_ok    <= 1'b0;
      div_wait <= div_ctl.start;
      rd_addr  <= idx[AddrW-1:0];
      sq_addr  <= rd_addr;
      sq       <= dev * dev;
      case (state)
        ST_LOAD: begin
          if (take) begin
            if (load_cnt < CntW'(MaxSamples)) begin
              keep[load_cnt[AddrW-1:0]] <= 1'b1;
              load_cnt <= load_cnt + 1'b1;
              kept     <= load_cnt + 1'b1;
            end else begin
              ovf  <= 1'b1;
              kept <= load_cnt;
            end
            pass   <= '0;
            result <= '0;
          end
        end
        ST_NEXT: begin
          idx   <= '0;
          sum   <= '0;
          sumsq <= '0;
          still <= '0;
        end
        ST_SUM: begin
          if (!walk_done) begin
            idx   <= idx + 1'b1;
            rd_ok <= 1'b1;
          end
          if (rd_ok && keep[rd_addr]) begin
            sum <= sum + SumW'(rd_data);
          end
        end
        ST_DIV: begin
          idx <= '0;
          if (!div_busy && !div_wait) begin
            mean   <= quot;
            result <= quot;
          end
        end
        ST_SQ, ST_CLIP: begin
          if (!walk_done) begin
            idx   <= idx + 1'b1;
            rd_ok <= 1'b1;
          end
          sq_ok <= rd_ok;
          if (sq_ok && keep[sq_addr]) begin
            if (state == ST_SQ) begin
              sumsq <= sumsq + SumSqW'(sq);
            end else if (lhs < rhs) begin
              still <= still + 1'b1;
            end else begin
              keep[sq_addr] <= 1'b0;
            end
          end
          if (walk_done && !rd_ok && !sq_ok) begin
            idx <= '0;
            if (state == ST_CLIP) begin
              kept <= still;
              pass <= pass + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            keep     <= '0;
            load_cnt <= '0;
            kept     <= '0;
            ovf      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid   = (state == ST_OUT);
  assign common_mode = result[23:0];
  assign kept_count  = (kept > CntW'(255)) ? 8'd255 : 8'(kept);
  assign overflow    = ovf;

  // Never hold more samples than the store.
  assert property (@(posedge clk) disable iff (rst) load_cnt <= CntW'(MaxSamples))
    else $error("load count beyond store");
  // Kept samples never exceed the stored ones.
  assert property (@(posedge clk) disable iff (rst) kept <= load_cnt)
    else $error("kept count beyond load count");
  // A result is offered only after the divider is idle.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !div_busy)
    else $error("result while dividing");

endmodule
